@@ rtl/core/ipru_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ipru_pkg
// Shared types and constants for the integer pixel replication upscaler.
// ============================================================================
package ipru_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int ADDR_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
    localparam int PIX_W      = 24;

    localparam int SCALE_W    = 7;
    localparam int SRC_W_W    = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int SCALE_MAX  = 100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_FACTOR = 1'b0,
        REG_SOURCE_WIDTH = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_PULL = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_PIXEL       = 2'd0,
        ST_LOAD_OK     = 2'd1,
        ST_LOAD_REJECT = 2'd2,
        ST_EMPTY       = 2'd3
    } t_status;

    typedef struct packed {
        logic       req_type;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       source_row_done;
    } t_rsp;

endpackage

@@ rtl/core/integer_pixel_replication_upscaler.sv @@
`timescale 1ns / 1ps
// ============================================================================
// integer_pixel_replication_upscaler
// Nearest-neighbour integer upscaler for 24-bit pixel rows, with line store.
// ============================================================================
// Accepts one transaction per clock when not stalled and returns exactly one
// response for each, through the stage-1 and output registers. Loads write
// the line store; once source_width pixels are in, pulls replay the row with
// each pixel repeated scale_factor times across and the row scale_factor times
// down. The line store is a 1024 x 24 RAM with a registered read that fills
// the pixel fields as a response moves from stage 1 to the output register;
// the row counters sit in flops and are updated at acceptance. The store
// needs no clearing after reset. Register writes abandon the row in progress.
module integer_pixel_replication_upscaler import ipru_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_req                  i_req,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_rsp                  o_rsp
);

    logic [SCALE_W-1:0] r_scale;
    logic [CNT_W-1:0]   r_width;
    logic [CNT_W-1:0]   r_loaded, n_loaded;
    logic [ADDR_W-1:0]  r_col, n_col;
    logic [SCALE_W-1:0] r_acr, n_acr;
    logic [SCALE_W-1:0] r_down, n_down;
    logic               r_replay, n_replay;
    logic               r_s1_v;
    t_rsp               r_s1_rsp;
    logic               r_out_v;
    t_rsp               r_out_rsp;

    t_rsp               rsp_new;
    t_rsp               s1_fill;
    logic               s1_adv;
    logic               acc;
    logic               ram_we;
    logic               ram_re;
    logic [PIX_W-1:0]   ram_rdata;
    logic [CNT_W-1:0]   loaded_inc;
    logic [CNT_W-1:0]   col_inc;
    logic [SCALE_W-1:0] acr_inc;
    logic [SCALE_W-1:0] down_inc;
    logic [3:0]         pad_prod;
    logic [SRC_W_W-1:0] cfg_w;
    logic [SCALE_W-1:0] cfg_s;

    assign s1_adv     = !r_out_v || !i_out_stall;
    assign o_in_stall = r_s1_v && !s1_adv;
    assign acc        = i_in_valid && !o_in_stall;

    assign loaded_inc = r_loaded + 1'b1;
    assign col_inc    = CNT_W'(r_col) + 1'b1;
    assign acr_inc    = r_acr + 1'b1;
    assign down_inc   = r_down + 1'b1;
    // pad = -(3*w*s) mod 4 = (w*s) mod 4
    assign pad_prod   = {2'b00, r_width[1:0]} * {2'b00, r_scale[1:0]};

    assign cfg_w = i_cfg_data[SRC_W_W-1:0];
    assign cfg_s = i_cfg_data[SCALE_W-1:0];

    always_comb begin
        n_loaded = r_loaded;
        n_col    = r_col;
        n_acr    = r_acr;
        n_down   = r_down;
        n_replay = r_replay;
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        rsp_new  = '0;
        if (acc) begin
            if (i_req.req_type == REQ_LOAD) begin
                if (r_replay || (r_loaded >= r_width)) begin
                    rsp_new.status = ST_LOAD_REJECT;
                end else begin
                    rsp_new.status = ST_LOAD_OK;
                    ram_we   = 1'b1;
                    n_loaded = loaded_inc;
                    if (loaded_inc >= r_width) begin
                        n_replay = 1'b1;
                        n_col    = '0;
                        n_acr    = '0;
                        n_down   = '0;
                    end
                end
            end else if (!r_replay) begin
                rsp_new.status = ST_EMPTY;
            end else begin
                rsp_new.status = ST_PIXEL;
                ram_re = 1'b1;
                if (acr_inc >= r_scale) begin
                    n_acr = '0;
                    if (col_inc >= r_width) begin
                        n_col             = '0;
                        rsp_new.row_end   = 1'b1;
                        rsp_new.pad_bytes = pad_prod[1:0];
                        if (down_inc >= r_scale) begin
                            rsp_new.source_row_done = 1'b1;
                            n_loaded = '0;
                            n_down   = '0;
                            n_replay = 1'b0;
                        end else begin
                            n_down = down_inc;
                        end
                    end else begin
                        n_col = col_inc[ADDR_W-1:0];
                    end
                end else begin
                    n_acr = acr_inc;
                end
            end
        end
        if (i_cfg_we) begin
            n_loaded = '0;
            n_col    = '0;
            n_acr    = '0;
            n_down   = '0;
            n_replay = 1'b0;
        end
    end

    always_comb begin
        s1_fill = r_s1_rsp;
        if (r_s1_rsp.status == ST_PIXEL) begin
            s1_fill.out_blue  = ram_rdata[7:0];
            s1_fill.out_green = ram_rdata[15:8];
            s1_fill.out_red   = ram_rdata[23:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= SCALE_W'(1);
            r_width  <= CNT_W'(1);
            r_loaded <= '0;
            r_col    <= '0;
            r_acr    <= '0;
            r_down   <= '0;
            r_replay <= 1'b0;
            r_s1_v   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_loaded <= n_loaded;
            r_col    <= n_col;
            r_acr    <= n_acr;
            r_down   <= n_down;
            r_replay <= n_replay;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SCALE_FACTOR: begin
                        if (cfg_s == '0) begin
                            r_scale <= SCALE_W'(1);
                        end else if (32'(cfg_s) > SCALE_MAX) begin
                            r_scale <= SCALE_W'(SCALE_MAX);
                        end else begin
                            r_scale <= cfg_s;
                        end
                    end
                    REG_SOURCE_WIDTH: begin
                        if (cfg_w == '0) begin
                            r_width <= CNT_W'(1);
                        end else if (32'(cfg_w) > MAX_WIDTH) begin
                            r_width <= CNT_W'(MAX_WIDTH);
                        end else begin
                            r_width <= CNT_W'(cfg_w);
                        end
                    end
                    default: begin
                        r_scale <= r_scale;
                    end
                endcase
            end

            if (acc) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end

            if (r_s1_v && s1_adv) begin
                r_out_v <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_rsp <= rsp_new;
        end
        if (r_s1_v && s1_adv) begin
            r_out_rsp <= s1_fill;
        end
    end

    ipru_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_loaded[ADDR_W-1:0]),
        .i_wdata ({i_req.in_red, i_req.in_green, i_req.in_blue}),
        .i_re    (ram_re),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_v;
    assign o_rsp       = r_out_rsp;

endmodule

@@ rtl/core/ipru_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ipru_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ============================================================================
module ipru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ rtl/core/ipru_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ipru_checker
// Port-level checks for the integer pixel replication upscaler.
// ============================================================================
module ipru_checker import ipru_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input t_rsp                  o_rsp
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_rsp))
        else $error("stalled response changed");

    a_non_pixel_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_rsp.status != ST_PIXEL) |->
            (o_rsp.out_blue == 8'd0) && (o_rsp.out_green == 8'd0) &&
            (o_rsp.out_red == 8'd0) && !o_rsp.row_end && !o_rsp.source_row_done)
        else $error("non-pixel response carries pixel fields");

    a_done_at_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rsp.source_row_done |-> o_rsp.row_end)
        else $error("row done without row end");

    a_pad_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rsp.row_end |-> (o_rsp.pad_bytes == 2'd0))
        else $error("pad bytes away from row end");

    a_no_early_resp: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid straight after reset");

endmodule

bind integer_pixel_replication_upscaler ipru_checker u_ipru_checker (.*);

@@ dv/integer_pixel_replication_upscaler_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// integer_pixel_replication_upscaler_tb
// Self-checking bench for the integer pixel replication upscaler.
// ============================================================================
// Fills the line store with source rows and pulls the replicated output, with
// stray loads and pulls mixed in. A predictor in the bench tracks fill and
// replay counters and expects one response per accepted transaction. Each
// response is compared field by field, in order. Runs cover the register
// extremes, abandoned rows, random geometry under several idle and stall
// mixes, and a long output hold-off.
module integer_pixel_replication_upscaler_tb;
    import ipru_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_req                  i_req       = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_rsp                  o_rsp;

    integer_pixel_replication_upscaler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req       (i_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // bench-side knobs
    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    int unsigned items_sent    = 0;
    int unsigned n_fail        = 0;
    int unsigned row_w         = 1;
    int unsigned row_s         = 1;
    int unsigned hold_len      = 0;
    logic        hold_go       = 1'b0;
    logic        hold_ack      = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;

    // predictor state
    logic [PIX_W-1:0]   row_mem [MAX_WIDTH];
    logic [SCALE_W-1:0] scale_q;
    logic [SRC_W_W-1:0] width_q;
    int unsigned        fill_cnt;
    int unsigned        col;
    int unsigned        across;
    int unsigned        down;
    logic               replay_q;
    t_rsp               pending_rsp_q [$];

    function automatic int unsigned eff_scale(input logic [SCALE_W-1:0] v);
        if (v == 0) return 1;
        if (v > SCALE_MAX) return SCALE_MAX;
        return 32'(v);
    endfunction

    function automatic int unsigned eff_width(input logic [SRC_W_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return 32'(v);
    endfunction

    task automatic abandon_row();
        fill_cnt = 0;
        col      = 0;
        across   = 0;
        down     = 0;
        replay_q = 1'b0;
    endtask

    task automatic predict_upscale(input t_req r, output t_rsp e);
        int unsigned w;
        int unsigned s;
        w = eff_width(width_q);
        s = eff_scale(scale_q);
        e = '0;
        if (r.req_type == REQ_LOAD) begin
            if (replay_q || fill_cnt >= w) begin
                e.status = ST_LOAD_REJECT;
            end else begin
                row_mem[fill_cnt[ADDR_W-1:0]] = {r.in_red, r.in_green, r.in_blue};
                fill_cnt++;
                if (fill_cnt >= w) begin
                    replay_q = 1'b1;
                    col      = 0;
                    across   = 0;
                    down     = 0;
                end
                e.status = ST_LOAD_OK;
            end
        end else if (!replay_q) begin
            e.status = ST_EMPTY;
        end else begin
            e.status = ST_PIXEL;
            {e.out_red, e.out_green, e.out_blue} = row_mem[col[ADDR_W-1:0]];
            across++;
            if (across >= s) begin
                across = 0;
                col++;
                if (col >= w) begin
                    col         = 0;
                    e.row_end   = 1'b1;
                    e.pad_bytes = 2'((4 - ((3 * w * s) % 4)) % 4);
                    down++;
                    if (down >= s) begin
                        e.source_row_done = 1'b1;
                        abandon_row();
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string fname, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, fname, exp_v, act_v);
            n_fail++;
        end
    endtask

    // monitor: register writes, accepted requests, accepted responses
    always @(posedge i_clk) begin
        t_rsp e;
        if (!i_rst_n) begin
            scale_q = SCALE_W'(1);
            width_q = SRC_W_W'(1);
            abandon_row();
            pending_rsp_q.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_rsp_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, got %p",
                             $time, o_rsp);
                    n_fail++;
                end else begin
                    e = pending_rsp_q.pop_front();
                    check_field("status",          e.status,          o_rsp.status);
                    check_field("out_blue",        e.out_blue,        o_rsp.out_blue);
                    check_field("out_green",       e.out_green,       o_rsp.out_green);
                    check_field("out_red",         e.out_red,         o_rsp.out_red);
                    check_field("row_end",         e.row_end,         o_rsp.row_end);
                    check_field("pad_bytes",       e.pad_bytes,       o_rsp.pad_bytes);
                    check_field("source_row_done", e.source_row_done,
                                o_rsp.source_row_done);
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_SCALE_FACTOR: scale_q = i_cfg_data[SCALE_W-1:0];
                    REG_SOURCE_WIDTH: width_q = i_cfg_data[SRC_W_W-1:0];
                    default: ;
                endcase
                abandon_row();
            end
            if (i_in_valid && !o_in_stall) begin
                predict_upscale(i_req, e);
                pending_rsp_q.push_back(e);
            end
        end
    end

    // receiver: random stall, or a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_go != hold_ack) begin
            hold_ack    <= hold_go;
            hold_left   <= hold_len;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time,
                     WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_req make_req(input t_req_type kind,
                                      input logic [PIX_W-1:0] pix);
        t_req r;
        r.req_type = kind;
        {r.in_red, r.in_green, r.in_blue} = pix;
        return r;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pix();
        return PIX_W'($urandom);
    endfunction

    function automatic t_req rand_req();
        return make_req(($urandom_range(1) == 0) ? REQ_LOAD : REQ_PULL, rand_pix());
    endfunction

    task automatic send_req(input t_req r);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req      <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] scale_data,
                                input logic [CFG_DATA_W-1:0] width_data);
        write_reg(REG_SCALE_FACTOR, scale_data);
        write_reg(REG_SOURCE_WIDTH, width_data);
        row_s = eff_scale(scale_data[SCALE_W-1:0]);
        row_w = eff_width(width_data[SRC_W_W-1:0]);
    endtask

    // fill one source row then replay it fully; stray transactions mixed in
    task automatic run_source_row(input int unsigned noise_pct);
        for (int unsigned i = 0; i < row_w; i++) begin
            if ($urandom_range(99) < noise_pct) send_req(rand_req());
            send_req(make_req(REQ_LOAD, rand_pix()));
        end
        for (int unsigned i = 0; i < row_w * row_s * row_s; i++) begin
            if ($urandom_range(99) < noise_pct) send_req(rand_req());
            send_req(make_req(REQ_PULL, rand_pix()));
        end
    endtask

    task automatic test_directed();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        send_req(make_req(REQ_PULL, 24'h000000));
        send_req(make_req(REQ_LOAD, 24'hFFFFFF));
        send_req(make_req(REQ_LOAD, 24'h000000));
        send_req(make_req(REQ_PULL, 24'hFFFFFF));
        send_req(make_req(REQ_PULL, 24'h000000));
        // zero in both registers acts as one
        set_geometry(11'd0, 11'd0);
        send_req(make_req(REQ_LOAD, 24'h000000));
        send_req(make_req(REQ_PULL, 24'h000000));
        set_geometry(11'd2, 11'd2);
        send_req(make_req(REQ_LOAD, 24'hA5C30F));
        send_req(make_req(REQ_LOAD, 24'h5A3CF0));
        repeat (8) send_req(make_req(REQ_PULL, 24'h000000));
        set_geometry(11'd1, 11'd3);
        send_req(make_req(REQ_LOAD, 24'h123456));
        send_req(make_req(REQ_LOAD, 24'hFEDCBA));
        send_req(make_req(REQ_LOAD, 24'h808080));
        repeat (3) send_req(make_req(REQ_PULL, 24'hFFFFFF));
    endtask

    task automatic test_abandon();
        in_idle_pct   = 20;
        out_stall_pct = 20;
        set_geometry(11'd2, 11'd3);
        send_req(make_req(REQ_LOAD, rand_pix()));
        send_req(make_req(REQ_LOAD, rand_pix()));
        set_geometry(11'd2, 11'd3);
        run_source_row(0);
        // part-way through the replay
        repeat (3) send_req(make_req(REQ_LOAD, rand_pix()));
        repeat (5) send_req(make_req(REQ_PULL, rand_pix()));
        write_reg(REG_SCALE_FACTOR, 11'd2);
        send_req(make_req(REQ_PULL, rand_pix()));
        run_source_row(0);
    endtask

    task automatic test_extremes();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        set_geometry(11'd100, 11'd1);
        send_req(make_req(REQ_LOAD, rand_pix()));
        send_req(make_req(REQ_PULL, rand_pix()));
        // above range acts as the maximum; abandoned part-way through the third output row
        set_geometry(11'h7FF, 11'd1);
        send_req(make_req(REQ_LOAD, rand_pix()));
        repeat (250) send_req(make_req(REQ_PULL, rand_pix()));
        // width above range acts as the full store
        set_geometry(11'd1, 11'h7FF);
        for (int unsigned i = 0; i < MAX_WIDTH; i++) begin
            send_req(make_req(REQ_LOAD, rand_pix()));
        end
        send_req(make_req(REQ_LOAD, rand_pix()));
        repeat (40) send_req(make_req(REQ_PULL, rand_pix()));
    endtask

    task automatic pick_geometry();
        int unsigned s;
        int unsigned w;
        if ($urandom_range(9) == 0) begin
            s = $urandom_range(10, 6);
            w = $urandom_range(2, 1);
        end else begin
            s = $urandom_range(5, 1);
            w = $urandom_range((16 < 60 / (s * s)) ? 16 : 60 / (s * s), 1);
        end
        if ($urandom_range(19) == 0) s = 0;
        set_geometry(CFG_DATA_W'(s), CFG_DATA_W'(w));
    endtask

    task automatic test_random_rows(input int unsigned in_pct, input int unsigned out_pct,
                                    input int unsigned n_items);
        int unsigned start;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        start         = items_sent;
        while (items_sent - start < n_items) begin
            if ($urandom_range(3) == 0) pick_geometry();
            run_source_row(8);
        end
    endtask

    task automatic test_backpressure();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        set_geometry(11'd3, 11'd4);
        hold_len = 300;
        hold_go  = ~hold_go;
        run_source_row(0);
        run_source_row(5);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_abandon();
        test_extremes();
        test_random_rows(0, 0, 80);
        test_random_rows(52, 0, 80);
        test_random_rows(0, 52, 80);
        test_random_rows(14, 14, 80);
        test_backpressure();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
